[design/segment_tree_range_sum_defines.svh]
// Assertion macros for the segment tree range-sum block.
// Included by the top level; no other dependencies.
`ifndef SEGMENT_TREE_RANGE_SUM_DEFINES_SVH
`define SEGMENT_TREE_RANGE_SUM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons holds in that cycle.
`define SGT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("segment tree: same-cycle check failed");
// Next-cycle implication: when ante holds, cons holds in the cycle after.
`define SGT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("segment tree: next-cycle check failed");
`else
`define SGT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SGT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[design/sgt_pkg.sv]
// Shared types and constants for the segment tree range-sum block.
// No dependencies.
`default_nettype none

package sgt_pkg;

    localparam int LEAVES_DEF = 1024;
    localparam int DATA_W     = 64;
    localparam int INDEX_W    = 10;
    localparam int BOUND_W    = 11;

    typedef logic [DATA_W-1:0] t_node;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

endpackage

`default_nettype wire

[design/sgt_mem.sv]
// Node store: one write port and one read port, registered read data.
// Depends on sgt_pkg.
`default_nettype none

module sgt_mem #(
    parameter int AW = 11
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire sgt_pkg::t_node  i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output sgt_pkg::t_node       o_rdata
);
    import sgt_pkg::*;

    t_node r_mem [0:(1 << AW)-1];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/segment_tree_range_sum.sv]
// Segment tree range-sum engine: top level with its control sequencer.
// Depends on sgt_pkg, sgt_mem and segment_tree_range_sum_defines.svh.
//
// Usage
//   A request beat is taken on the rising edge where start is high and busy
//   is low. i_req_type selects a leaf write or a range query.
//   A write stores i_leaf_value at leaf i_leaf_index and rebuilds every
//   ancestor sum on the way to the root. It gives no result. An index past
//   the last leaf is dropped at once.
//   A query returns the wrapped sum of leaves [i_range_lo, i_range_hi);
//   bounds past the leaf count saturate, an empty range returns zero.
//   The result beat shows on o_range_sum for one cycle with o_valid high;
//   the receiver cannot stall it, so take it on that cycle.
// Timing
//   Write: one node level per cycle, the leaf first and then each ancestor
//   up to the root, set by the single write port of the node memory.
//   Query: each tree level takes a left step (ST_QL) and a right step
//   (ST_QR), each with at most one read of the single read port; the
//   result beat shows in the same cycle that busy drops.
// Reset
//   After reset the node memory is swept to zero, one entry per cycle,
//   with busy held high.
`default_nettype none

`include "segment_tree_range_sum_defines.svh"

module segment_tree_range_sum #(
    parameter int LEAVES = sgt_pkg::LEAVES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_req_type,
    input  wire logic [sgt_pkg::INDEX_W-1:0]   i_leaf_index,
    input  wire logic signed [sgt_pkg::DATA_W-1:0] i_leaf_value,
    input  wire logic [sgt_pkg::BOUND_W-1:0]   i_range_lo,
    input  wire logic [sgt_pkg::BOUND_W-1:0]   i_range_hi,
    output logic                               o_valid,
    output logic signed [sgt_pkg::DATA_W-1:0]  o_range_sum
);
    import sgt_pkg::*;

    // LW: tree depth, AW: node address, QW: query cursor (reaches 2*LEAVES)
    localparam int LW = $clog2(LEAVES);
    localparam int AW = LW + 1;
    localparam int QW = LW + 2;
    localparam int EW = (QW > BOUND_W) ? QW : BOUND_W;
    localparam logic [EW-1:0] LEAVES_E = EW'(LEAVES);
    localparam logic [AW-1:0] LEAF_BASE_A = AW'(LEAVES);
    localparam logic [QW-1:0] LEAF_BASE_Q = QW'(LEAVES);
    localparam logic [AW-1:0] ROOT_A = AW'(1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLR   = 6'b000010,
        ST_WLEAF = 6'b000100,
        ST_WUP   = 6'b001000,
        ST_QL    = 6'b010000,
        ST_QR    = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    logic [AW-1:0]   r_node, n_node;     // write walk: node last written
    t_node           r_cur, n_cur;       // write walk: value of r_node
    logic [QW-1:0]   r_l, n_l;
    logic [QW-1:0]   r_r, n_r;
    t_node           r_acc, n_acc;
    logic            r_pend, n_pend;     // a read was issued last cycle
    t_node           r_out, n_out;
    logic            r_vld, n_vld;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_node           mem_wdata;
    logic [AW-1:0]   mem_raddr;
    t_node           mem_rdata;

    logic            accept;
    logic [EW-1:0]   idx_e, lo_e, hi_e, lo_s, hi_s;
    t_node           sum_up;
    t_node           acc_sum;
    logic [AW-1:0]   parent;

    sgt_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // widen the request fields and clamp the range bounds
    assign idx_e = EW'(i_leaf_index);
    assign lo_e  = EW'(i_range_lo);
    assign hi_e  = EW'(i_range_hi);
    assign lo_s  = (lo_e > LEAVES_E) ? LEAVES_E : lo_e;
    assign hi_s  = (hi_e > LEAVES_E) ? LEAVES_E : hi_e;

    assign parent  = r_node >> 1;
    assign sum_up  = r_cur + mem_rdata;
    assign acc_sum = r_acc + (r_pend ? mem_rdata : '0);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_node    = r_node;
        n_cur     = r_cur;
        n_l       = r_l;
        n_r       = r_r;
        n_acc     = r_acc;
        n_pend    = 1'b0;
        n_out     = r_out;
        n_vld     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = r_cur;
        mem_raddr = r_node ^ AW'(1);

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_WRITE) begin
                        // drop writes aimed past the last leaf
                        if (idx_e < LEAVES_E) begin
                            n_node  = AW'(idx_e) + LEAF_BASE_A;
                            n_cur   = $unsigned(i_leaf_value);
                            n_state = ST_WLEAF;
                        end
                    end else begin
                        n_l     = QW'(lo_s) + LEAF_BASE_Q;
                        n_r     = QW'(hi_s) + LEAF_BASE_Q;
                        n_acc   = '0;
                        n_state = ST_QL;
                    end
                end
            end
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == {AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WLEAF: begin
                // store the leaf and fetch its sibling in the same cycle
                mem_we  = 1'b1;
                n_state = ST_WUP;
            end
            ST_WUP: begin
                // parent = this node + sibling; fetch the parent's sibling
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = sum_up;
                mem_raddr = parent ^ AW'(1);
                n_cur     = sum_up;
                n_node    = parent;
                if (parent == ROOT_A) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QL: begin
                n_acc = acc_sum;
                if (r_l < r_r) begin
                    if (r_l[0]) begin
                        mem_raddr = r_l[AW-1:0];
                        n_pend    = 1'b1;
                        n_l       = r_l + QW'(1);
                    end
                    n_state = ST_QR;
                end else begin
                    n_out   = acc_sum;
                    n_vld   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_QR: begin
                n_acc = acc_sum;
                if (r_r[0]) begin
                    mem_raddr = r_r[AW-1:0] - AW'(1);
                    n_pend    = 1'b1;
                end
                // advance both cursors one level up
                n_l     = r_l >> 1;
                n_r     = r_r >> 1;
                n_state = ST_QL;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_vld   <= n_vld;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_cur  <= n_cur;
        r_l    <= n_l;
        r_r    <= n_r;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    assign o_valid     = r_vld;
    assign o_range_sum = $signed(r_out);

    // a result beat only ever follows the closing step of a query
    `SGT_ASSERT_IMP(a_vld_after_query, i_clk, i_rst_n, o_valid, $past(r_state == ST_QL))
    // a query walk never disturbs the node store
    `SGT_ASSERT_IMP(a_query_no_write, i_clk, i_rst_n, (r_state == ST_QL) || (r_state == ST_QR), !mem_we)
    // an accepted write never yields a result beat
    `SGT_ASSERT_NXT(a_write_silent, i_clk, i_rst_n, accept && (i_req_type == REQ_WRITE), !o_valid)

endmodule

`default_nettype wire

[sim/tb_segment_tree_range_sum.sv]
// Self-checking bench for segment_tree_range_sum: leaf writes and range-sum queries.
// Depends on sgt_pkg and the design; expected sums come from a local copy of the tree.
module tb_segment_tree_range_sum;
    import sgt_pkg::*;

    localparam int N_LEAVES = LEAVES_DEF;
    localparam int N_NODES  = 2 * N_LEAVES;
    localparam int N_RANDOM = 1030;
    localparam int PHASE_LEN = 260;
    // Longest quiet stretch of a good run: the clearing sweep after reset,
    // then at worst a drain pause (a query walk and its result beat) or a short
    // random gap. Allow several times the sweep.
    localparam int STALL_LIMIT = 10000;
    localparam int TAIL_CYCLES = 40;

    // One request beat as queued for the driver.
    typedef struct {
        logic                 kind;
        logic [INDEX_W-1:0]   index;
        t_node                value;
        logic [BOUND_W-1:0]   lo;
        logic [BOUND_W-1:0]   hi;
        int unsigned          idle_pct;
        bit                   drain;
    } t_req_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_req_type = REQ_WRITE;
    logic [INDEX_W-1:0]   i_leaf_index = '0;
    logic signed [DATA_W-1:0] i_leaf_value = '0;
    logic [BOUND_W-1:0]   i_range_lo = '0;
    logic [BOUND_W-1:0]   i_range_hi = '0;
    logic                 o_valid;
    logic signed [DATA_W-1:0] o_range_sum;

    t_req_beat   req_pending[$];
    t_req_beat   cur_req;
    t_node       sum_expected[$];
    t_node       tree_sum [1:N_NODES-1];
    int          sums_issued = 0;
    int          sums_seen = 0;
    int          fail_cnt = 0;
    int          quiet_cycles = 0;

    // Idle plan per phase: none, heavy, none, light.
    int unsigned idle_plan [4] = '{0, 45, 0, 22};
    int unsigned phase_idle = 0;
    bit          drain_next = 1'b0;

    segment_tree_range_sum DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_leaf_index (i_leaf_index),
        .i_leaf_value (i_leaf_value),
        .i_range_lo   (i_range_lo),
        .i_range_hi   (i_range_hi),
        .o_valid      (o_valid),
        .o_range_sum  (o_range_sum)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Tree copy: heap numbering from 1, leaves at N_LEAVES and above.
    // ---------------------------------------------------------------
    function automatic void store_leaf(int unsigned idx, t_node val);
        int unsigned k;
        if (idx >= N_LEAVES) return;
        k = idx + N_LEAVES;
        tree_sum[k] = val;
        // rebuild every ancestor up to the root
        for (k = k >> 1; k >= 1; k = k >> 1)
            tree_sum[k] = tree_sum[2*k] + tree_sum[2*k+1];
    endfunction

    function automatic t_node sum_range(int unsigned lo, int unsigned hi);
        t_node       acc;
        int unsigned l;
        int unsigned r;
        acc = '0;
        // saturate both bounds to the leaf count
        if (lo > N_LEAVES) lo = N_LEAVES;
        if (hi > N_LEAVES) hi = N_LEAVES;
        if (lo >= hi) return '0;
        l = lo + N_LEAVES;
        r = hi + N_LEAVES;
        // bottom-up walk: take node l when l is a right child, and the
        // node left of r when r is a right child
        while (l < r) begin
            if (l & 1) begin
                acc = acc + tree_sum[l];
                l++;
            end
            if (r & 1) begin
                r--;
                acc = acc + tree_sum[r];
            end
            l = l >> 1;
            r = r >> 1;
        end
        return acc;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_node pick_value();
        case ($urandom_range(5))
            0:       return t_node'($signed($urandom_range(16)) - 8);
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return {1'b1, {(DATA_W-1){1'b0}}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_beat(logic kind, logic [INDEX_W-1:0] idx, t_node val,
                              logic [BOUND_W-1:0] lo, logic [BOUND_W-1:0] hi);
        t_req_beat b;
        b.kind     = kind;
        b.index    = idx;
        b.value    = val;
        b.lo       = lo;
        b.hi       = hi;
        b.idle_pct = phase_idle;
        b.drain    = drain_next;
        drain_next = 1'b0;
        req_pending = {req_pending, b};
    endtask

    // Fields that the request kind ignores get random junk.
    task automatic queue_write(logic [INDEX_W-1:0] idx, t_node val);
        queue_beat(REQ_WRITE, idx, val, BOUND_W'($urandom), BOUND_W'($urandom));
    endtask

    task automatic queue_query(logic [BOUND_W-1:0] lo, logic [BOUND_W-1:0] hi);
        queue_beat(REQ_QUERY, INDEX_W'($urandom), {$urandom, $urandom}, lo, hi);
    endtask

    task automatic queue_random_query();
        int unsigned a;
        int unsigned b;
        case ($urandom_range(9))
            6: begin
                // narrow window, possibly running off the end
                a = $urandom_range(N_LEAVES);
                b = a + $urandom_range(3);
            end
            7: begin
                // reversed or empty
                b = $urandom_range(N_LEAVES);
                a = b + $urandom_range(20);
            end
            8: begin
                // any 11-bit bounds, including those past the leaf count
                a = $urandom_range(2**BOUND_W - 1);
                b = $urandom_range(2**BOUND_W - 1);
            end
            9: begin
                a = 0;
                b = $urandom_range(1) ? N_LEAVES : 2**BOUND_W - 1;
            end
            default: begin
                a = $urandom_range(N_LEAVES);
                b = $urandom_range(N_LEAVES);
                if (a > b) begin
                    a = a ^ b;
                    b = a ^ b;
                    a = a ^ b;
                end
            end
        endcase
        if (a > 2**BOUND_W - 1) a = 2**BOUND_W - 1;
        if (b > 2**BOUND_W - 1) b = 2**BOUND_W - 1;
        queue_query(BOUND_W'(a), BOUND_W'(b));
    endtask

    // ---------------------------------------------------------------
    // Driver: launch the next beat once the current one is taken, or
    // hold it while busy is high. Drop start while idle and scribble
    // the fields so the block must ignore them.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        bit        taken;
        bit        launch;
        t_req_beat nxt;
        taken = i_rst_n && start && !busy;
        if (taken) begin
            if (cur_req.kind == REQ_WRITE) begin
                store_leaf(32'(cur_req.index), cur_req.value);
            end else begin
                sum_expected = {sum_expected, sum_range(32'(cur_req.lo), 32'(cur_req.hi))};
                sums_issued <= sums_issued + 1;
            end
        end
        launch = 1'b0;
        if (i_rst_n && (!start || taken) && req_pending.size() > 0) begin
            if (req_pending[0].drain)
                // hold off until every issued query has returned its beat
                launch = !taken && (sums_issued == sums_seen + int'(o_valid));
            else
                launch = $urandom_range(99) >= req_pending[0].idle_pct;
        end
        if (launch) begin
            nxt = req_pending.pop_front();
            cur_req      <= nxt;
            start        <= 1'b1;
            i_req_type   <= nxt.kind;
            i_leaf_index <= nxt.index;
            i_leaf_value <= nxt.value;
            i_range_lo   <= nxt.lo;
            i_range_hi   <= nxt.hi;
        end else if (!start || taken) begin
            start        <= 1'b0;
            i_req_type   <= 1'($urandom);
            i_leaf_index <= INDEX_W'($urandom);
            i_leaf_value <= {$urandom, $urandom};
            i_range_lo   <= BOUND_W'($urandom);
            i_range_hi   <= BOUND_W'($urandom);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every result beat must match the oldest expected sum.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_node want;
        if (i_rst_n && o_valid) begin
            sums_seen <= sums_seen + 1;
            if (sum_expected.size() == 0) begin
                $error("range_sum: no sum expected, actual %0h", o_range_sum);
                fail_cnt++;
            end else begin
                want = sum_expected.pop_front();
                if (o_range_sum !== want) begin
                    $error("range_sum: expected %0h actual %0h", want, o_range_sum);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Sequence: fill the request queue, release reset, wait for drain.
    // ---------------------------------------------------------------
    initial begin
        foreach (tree_sum[k]) tree_sum[k] = '0;

        // Directed part: empty tree, extreme values and leaves, wrap-round,
        // saturated, empty and reversed bounds, overwrite, junk fields.
        queue_query('0, BOUND_W'(N_LEAVES));
        queue_write('0, {1'b0, {(DATA_W-1){1'b1}}});
        queue_write(INDEX_W'(N_LEAVES - 1), {1'b1, {(DATA_W-1){1'b0}}});
        queue_write(INDEX_W'(N_LEAVES / 2), '1);
        queue_query('0, BOUND_W'(N_LEAVES));
        queue_query('0, BOUND_W'(1));
        queue_query(BOUND_W'(N_LEAVES - 1), BOUND_W'(N_LEAVES));
        queue_query(BOUND_W'(N_LEAVES), BOUND_W'(N_LEAVES));
        queue_query(BOUND_W'(5), BOUND_W'(3));
        queue_query('0, '0);
        queue_query('0, '1);
        queue_query('1, '1);
        queue_query(BOUND_W'(1500), BOUND_W'(2000));
        queue_write(INDEX_W'(1), {1'b0, {(DATA_W-1){1'b1}}});
        queue_query('0, BOUND_W'(2));
        queue_write('0, 64'h0123_4567_89AB_CDEF);
        queue_query('0, BOUND_W'(1));
        queue_write(INDEX_W'(N_LEAVES / 2 + 1), '0);
        queue_query(BOUND_W'(N_LEAVES / 2), BOUND_W'(N_LEAVES - 1));
        queue_query(BOUND_W'(1), BOUND_W'(N_LEAVES - 1));
        drain_next = 1'b1;
        queue_query(BOUND_W'(1), BOUND_W'(2));

        // Random part: writes hit a hot corner often so leaves get
        // overwritten; queries mix in-range, narrow, empty and out-of-range.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % PHASE_LEN == 0) begin
                phase_idle = idle_plan[(n / PHASE_LEN) % 4];
                drain_next = 1'b1;
            end
            if ($urandom_range(99) < 3) drain_next = 1'b1;
            if ($urandom_range(99) < 45) begin
                if ($urandom_range(99) < 30)
                    queue_write(INDEX_W'($urandom_range(15)), pick_value());
                else
                    queue_write(INDEX_W'($urandom), pick_value());
            end else begin
                queue_random_query();
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every beat to be taken, every sum to return, then let the
        // block settle past its longest busy stretch.
        while (req_pending.size() != 0 || start) @(posedge i_clk);
        while (sums_issued != sums_seen) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sum_expected.size() != 0) begin
            $error("range_sum: %0d expected sums never arrived", sum_expected.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
